// ----- rtl/core/bbfd_pkg.sv -----
// ----------------------------------------------------------------------------
// bbfd_pkg
// Shared types, constants and command lookup for the boiler bus frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bbfd_pkg;

    localparam int SENSOR_COUNT = 15;
    localparam int SLOT_COUNT   = 4;   // most updates one frame can cause
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    typedef logic [3:0] t_sid;
    typedef logic [7:0] t_byte;
    typedef logic [8:0] t_value;

    // frame bytes
    localparam t_byte SYNC_CTRL = 8'h53;
    localparam t_byte SYNC_DEV  = 8'h44;
    localparam t_byte FRAME_END = 8'h06;

    // controller commands
    localparam t_byte CMD_FLOW_TGT  = 8'h6E;
    localparam t_byte CMD_HEAT_DAY  = 8'h72;
    localparam t_byte CMD_WATER_DAY = 8'h74;
    localparam t_byte CMD_MODE      = 8'h67;
    localparam t_byte CMD_DWT_OUT   = 8'h71;
    // device commands
    localparam t_byte CMD_OUTSIDE   = 8'h6C;
    localparam t_byte CMD_FLOW      = 8'h68;
    localparam t_byte CMD_WATER     = 8'h6A;
    localparam t_byte CMD_WATER_TGT = 8'h6F;
    localparam t_byte CMD_ERROR     = 8'h65;
    localparam t_byte CMD_RPM       = 8'hA0;
    localparam t_byte CMD_STATUS    = 8'h70;

    // sensor ids
    localparam t_sid SID_FLOW_TGT  = 4'd0;
    localparam t_sid SID_HEAT_DAY  = 4'd1;
    localparam t_sid SID_WATER_DAY = 4'd2;
    localparam t_sid SID_MODE      = 4'd3;
    localparam t_sid SID_DWT_OUT   = 4'd4;
    localparam t_sid SID_OUTSIDE   = 4'd5;
    localparam t_sid SID_FLOW      = 4'd6;
    localparam t_sid SID_WATER     = 4'd7;
    localparam t_sid SID_WATER_TGT = 4'd8;
    localparam t_sid SID_ERROR     = 4'd9;
    localparam t_sid SID_RPM       = 4'd10;
    localparam t_sid SID_STATUS    = 4'd11;
    localparam t_sid SID_PUMP      = 4'd12;
    localparam t_sid SID_HEAT      = 4'd13;
    localparam t_sid SID_VALVE     = 4'd14;

    localparam logic [SENSOR_COUNT-1:0] ENABLE_RESET = '1;

    typedef struct packed {
        logic known;
        logic status;   // status word: fans out to four sensors
        logic sgn;      // value is a signed byte
        t_sid id;
    } t_cmd_info;

    // one decoded frame, handed from front to back
    typedef struct packed {
        logic  status;
        logic  sgn;
        t_sid  id;
        t_byte val;
    } t_job;

    function automatic t_cmd_info ctrl_lookup(input t_byte cmd);
        t_cmd_info r;
        r = '0;
        r.known = 1'b1;
        unique case (cmd)
            CMD_FLOW_TGT:  r.id = SID_FLOW_TGT;
            CMD_HEAT_DAY:  r.id = SID_HEAT_DAY;
            CMD_WATER_DAY: r.id = SID_WATER_DAY;
            CMD_MODE:      r.id = SID_MODE;
            CMD_DWT_OUT: begin
                r.id  = SID_DWT_OUT;
                r.sgn = 1'b1;
            end
            default:       r.known = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_cmd_info dev_lookup(input t_byte cmd);
        t_cmd_info r;
        r = '0;
        r.known = 1'b1;
        unique case (cmd)
            CMD_OUTSIDE: begin
                r.id  = SID_OUTSIDE;
                r.sgn = 1'b1;
            end
            CMD_FLOW:      r.id = SID_FLOW;
            CMD_WATER:     r.id = SID_WATER;
            CMD_WATER_TGT: r.id = SID_WATER_TGT;
            CMD_ERROR:     r.id = SID_ERROR;
            CMD_RPM:       r.id = SID_RPM;
            CMD_STATUS: begin
                r.id     = SID_STATUS;
                r.status = 1'b1;
            end
            default:       r.known = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bbfd_front.sv -----
// ----------------------------------------------------------------------------
// bbfd_front
// Eight-byte sliding window, frame check and command classification.
// ----------------------------------------------------------------------------
`default_nettype none

module bbfd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire bbfd_pkg::t_byte i_byte,
    output logic               o_push,
    output bbfd_pkg::t_job     o_job
);

    bbfd_pkg::t_byte r_win [0:6];
    logic [2:0]      r_count;
    bbfd_pkg::t_byte w [0:7];     // full window once the new byte lands
    logic            full;
    logic            ctrl_hdr, dev_hdr, ctrl_ok, dev_ok, frame_ok;
    bbfd_pkg::t_cmd_info ci, di, info;

    always_comb begin
        for (int i = 0; i < 7; i++) begin
            w[i] = r_win[i];
        end
        w[7] = i_byte;
    end

    assign full = (r_count == 3'd7);

    assign ctrl_hdr = (w[0] == bbfd_pkg::SYNC_CTRL) && (w[1] == bbfd_pkg::SYNC_CTRL);
    assign dev_hdr  = (w[0] == bbfd_pkg::SYNC_DEV)  && (w[1] == bbfd_pkg::SYNC_DEV);
    assign ctrl_ok  = ctrl_hdr && (w[2] == w[3]) && (w[4] == w[5])
                      && (w[6] == bbfd_pkg::FRAME_END) && (w[4] == w[7]);
    assign dev_ok   = dev_hdr && (w[2] == w[3]) && (w[2] == w[4])
                      && (w[7] == bbfd_pkg::FRAME_END);
    assign frame_ok = full && (ctrl_ok || dev_ok);

    assign ci   = bbfd_pkg::ctrl_lookup(w[2]);
    assign di   = bbfd_pkg::dev_lookup(w[2]);
    assign info = ctrl_ok ? ci : di;

    // unknown command: frame still consumed, nothing queued
    assign o_push       = i_accept && frame_ok && info.known;
    assign o_job.status = info.status;
    assign o_job.sgn    = info.sgn;
    assign o_job.id     = info.id;
    assign o_job.val    = ctrl_ok ? w[4] : w[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            if (!full) begin
                r_count <= r_count + 3'd1;
            end else if (frame_ok) begin
                r_count <= '0;
            end
        end
    end

    // window payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (!full) begin
                r_win[r_count] <= i_byte;
            end else if (!frame_ok) begin
                for (int i = 0; i < 7; i++) begin
                    r_win[i] <= w[i+1];
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bbfd_queue.sv -----
// ----------------------------------------------------------------------------
// bbfd_queue
// Small FIFO of decoded frames between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module bbfd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire bbfd_pkg::t_job i_job,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output bbfd_pkg::t_job     o_job
);

    localparam int PW = bbfd_pkg::QPTR_W;

    bbfd_pkg::t_job r_mem [0:bbfd_pkg::QUEUE_DEPTH-1];
    logic [PW-1:0]  r_wr, r_rd;
    logic [PW:0]    r_fill;
    logic           do_push, do_pop;

    assign o_full  = (r_fill == (PW+1)'(bbfd_pkg::QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + (PW+1)'(1);
                2'b01:   r_fill <= r_fill - (PW+1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bbfd_back.sv -----
// ----------------------------------------------------------------------------
// bbfd_back
// Change filter per sensor and update sequencer: one frame's updates go out
// one word per cycle while i_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bbfd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_wen,
    input  wire logic [bbfd_pkg::SENSOR_COUNT-1:0] i_cfg_wdata,
    input  wire logic          i_job_valid,
    input  wire bbfd_pkg::t_job i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output bbfd_pkg::t_sid     o_id,
    output bbfd_pkg::t_value   o_value,
    output logic               o_last
);

    localparam int NS = bbfd_pkg::SENSOR_COUNT;
    localparam int NK = bbfd_pkg::SLOT_COUNT;

    logic [NS-1:0]     r_enable;
    logic [NS-1:0]     r_seen;
    bbfd_pkg::t_byte   r_last_val [0:NS-1];
    logic [NK-1:0]     r_pend;
    bbfd_pkg::t_sid    r_id  [0:NK-1];
    bbfd_pkg::t_value  r_val [0:NK-1];

    bbfd_pkg::t_sid    s_id  [0:NK-1];
    bbfd_pkg::t_byte   s_byte[0:NK-1];
    bbfd_pkg::t_value  s_val [0:NK-1];
    logic [NK-1:0]     s_on, s_emit;
    logic [NK-1:0]     low_bit, rest;
    logic [1:0]        sel;
    logic              fire, load;

    // slot 0 is the frame's own sensor; status adds pump, heat, valve
    always_comb begin
        s_id[0]   = i_job.status ? bbfd_pkg::SID_STATUS : i_job.id;
        s_id[1]   = bbfd_pkg::SID_PUMP;
        s_id[2]   = bbfd_pkg::SID_HEAT;
        s_id[3]   = bbfd_pkg::SID_VALVE;
        s_byte[0] = i_job.val;
        s_byte[1] = {7'b0, i_job.val[2]};
        s_byte[2] = {7'b0, i_job.val[0]};
        s_byte[3] = {7'b0, i_job.val[1]};
        s_val[0]  = {i_job.sgn & i_job.val[7], i_job.val};
        for (int k = 1; k < NK; k++) begin
            s_val[k] = {1'b0, s_byte[k]};
        end
        s_on = {{(NK-1){i_job.status}}, 1'b1};
        for (int k = 0; k < NK; k++) begin
            s_emit[k] = s_on[k] && r_enable[s_id[k]]
                        && (!r_seen[s_id[k]] || (r_last_val[s_id[k]] != s_byte[k]));
        end
    end

    assign low_bit = r_pend & (~r_pend + NK'(1));
    assign rest    = r_pend & ~low_bit;

    always_comb begin
        priority casez (r_pend)
            4'b???1: sel = 2'd0;
            4'b??10: sel = 2'd1;
            4'b?100: sel = 2'd2;
            default: sel = 2'd3;
        endcase
    end

    assign o_valid = |r_pend;
    assign o_id    = r_id[sel];
    assign o_value = r_val[sel];
    assign o_last  = (rest == '0);
    assign fire    = o_valid && i_ready;
    assign load    = i_job_valid && (!o_valid || (fire && o_last));
    assign o_pop   = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= bbfd_pkg::ENABLE_RESET;
            r_seen   <= '0;
            r_pend   <= '0;
        end else begin
            if (i_cfg_wen) begin
                r_enable <= i_cfg_wdata;
            end
            if (load) begin
                r_pend <= s_emit;
                for (int k = 0; k < NK; k++) begin
                    if (s_emit[k]) begin
                        r_seen[s_id[k]] <= 1'b1;
                    end
                end
            end else if (fire) begin
                r_pend <= rest;
            end
        end
    end

    // payload: last published values and staged updates
    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int k = 0; k < NK; k++) begin
                r_id[k]  <= s_id[k];
                r_val[k] <= s_val[k];
                if (s_emit[k]) begin
                    r_last_val[s_id[k]] <= s_byte[k];
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/boiler_bus_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// boiler_bus_frame_decoder
// Finds controller and device frames in a serial byte stream and publishes
// changed sensor values.
// ----------------------------------------------------------------------------
//
//  channel   dir  word                          handshake
//  s_axis    in   tdata[7:0] rx_byte            tvalid/tready
//  m_axis    out  tdata[3:0] sensor_id,         tvalid/tready
//                 tdata[12:4] sensor_value,
//                 tlast last_of_run
//  cfg       in   i_cfg_wdata[14:0] enable      i_cfg_wen, no wait
//
//  One byte per cycle is accepted while the frame queue has room; a byte
//  that completes a frame is decoded in that same cycle and queued.
//  The back end emits one update word per cycle while m_axis_tready is high;
//  a status frame gives up to four, all other frames at most one. A frame
//  with no changes is popped without a word. Output stalls fill the 4-entry
//  frame queue before the input stalls. Synchronous reset empties window
//  and queue, clears the seen flags and sets all sensors enabled.
//
// ----------------------------------------------------------------------------
`default_nettype none

module boiler_bus_frame_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config
    input  wire logic        i_cfg_wen,
    input  wire logic [14:0] i_cfg_wdata,     // [14:0] sensor_enable
    // byte stream in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
    // update stream out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,    // [3:0] sensor_id, [12:4] sensor_value
    output logic             m_axis_tlast     // last_of_run
);

    logic             accept;
    logic             push, q_full, q_empty, pop;
    bbfd_pkg::t_job   f_job, q_job;
    bbfd_pkg::t_sid   out_id;
    bbfd_pkg::t_value out_val;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    bbfd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .o_push   (push),
        .o_job    (f_job)
    );

    // decoded frames waiting for the back end
    bbfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    bbfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_job_valid (!q_empty),
        .i_job       (q_job),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_id        (out_id),
        .o_value     (out_val),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_val, out_id};

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for boiler_bus_frame_decoder. A queue-fed driver streams
// serial bytes, a clocked monitor runs a bit-exact decoder model on every
// accepted byte and checks each update word against the oldest expected one.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;   // long receiver stall, fills the frame queue
    localparam int DRAIN_GAP   = 24;    // back end may still chew on silent frames

    localparam bbfd_pkg::t_byte CTRL_CMDS [5] = '{
        bbfd_pkg::CMD_FLOW_TGT, bbfd_pkg::CMD_HEAT_DAY, bbfd_pkg::CMD_WATER_DAY,
        bbfd_pkg::CMD_MODE, bbfd_pkg::CMD_DWT_OUT};
    localparam bbfd_pkg::t_byte DEV_CMDS [7]  = '{
        bbfd_pkg::CMD_OUTSIDE, bbfd_pkg::CMD_FLOW, bbfd_pkg::CMD_WATER,
        bbfd_pkg::CMD_WATER_TGT, bbfd_pkg::CMD_ERROR, bbfd_pkg::CMD_RPM,
        bbfd_pkg::CMD_STATUS};

    // one update word as the back end should emit it
    typedef struct packed {
        bbfd_pkg::t_sid   sid;
        bbfd_pkg::t_value value;
        logic             last;
    } t_update;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wen     = 1'b0;
    logic [14:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;     // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [3:0] sensor_id, [12:4] sensor_value
    logic        m_axis_tlast;           // last_of_run

    boiler_bus_frame_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // stimulus and scoreboard state
    bbfd_pkg::t_byte tx_bytes[$];   // bytes waiting for the driver
    t_update pending_updates[$];    // updates predicted but not yet seen
    t_update got_upd;
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      send_idle_pct  = 0;
    int      recv_idle_pct  = 0;
    logic    hold_armed     = 1'b0;
    logic    hold_done      = 1'b0;
    int      hold_cnt       = 0;

    // decoder model state
    logic [bbfd_pkg::SENSOR_COUNT-1:0] mdl_enable = bbfd_pkg::ENABLE_RESET;
    logic [bbfd_pkg::SENSOR_COUNT-1:0] mdl_seen   = '0;
    bbfd_pkg::t_byte                   mdl_last [bbfd_pkg::SENSOR_COUNT];
    bbfd_pkg::t_byte                   win [8];
    int                                win_cnt    = 0;

    initial begin
        for (int i = 0; i < bbfd_pkg::SENSOR_COUNT; i++) mdl_last[i] = '0;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    // Emit an update if the sensor is enabled and its value moved, or it
    // has never been published (seen flag forces the first one out).
    function automatic void publish(input bbfd_pkg::t_sid sid, input bbfd_pkg::t_byte val,
                                    input bit sgn);
        t_update u;
        if (!mdl_enable[sid]) return;
        if (mdl_seen[sid] && mdl_last[sid] == val) return;
        mdl_seen[sid] = 1'b1;
        mdl_last[sid] = val;
        u.sid   = sid;
        u.value = sgn ? {val[7], val} : {1'b0, val};
        u.last  = 1'b0;
        pending_updates = {pending_updates, u};
    endfunction

    // Check the full window; returns 1 when a frame (known command or not)
    // was found and consumed.
    function automatic bit frame_match();
        bbfd_pkg::t_byte c;
        bbfd_pkg::t_byte v;
        c = win[2];
        if (win[0] == bbfd_pkg::SYNC_CTRL && win[1] == bbfd_pkg::SYNC_CTRL) begin
            v = win[4];
            if (c != win[3] || v != win[5] || win[6] != bbfd_pkg::FRAME_END || v != win[7])
                return 1'b0;
            case (c)
                bbfd_pkg::CMD_FLOW_TGT:  publish(bbfd_pkg::SID_FLOW_TGT,  v, 1'b0);
                bbfd_pkg::CMD_HEAT_DAY:  publish(bbfd_pkg::SID_HEAT_DAY,  v, 1'b0);
                bbfd_pkg::CMD_WATER_DAY: publish(bbfd_pkg::SID_WATER_DAY, v, 1'b0);
                bbfd_pkg::CMD_MODE:      publish(bbfd_pkg::SID_MODE,      v, 1'b0);
                bbfd_pkg::CMD_DWT_OUT:   publish(bbfd_pkg::SID_DWT_OUT,   v, 1'b1);
                default: ;
            endcase
            return 1'b1;
        end
        if (win[0] == bbfd_pkg::SYNC_DEV && win[1] == bbfd_pkg::SYNC_DEV) begin
            v = win[5];
            if (c != win[3] || c != win[4] || win[7] != bbfd_pkg::FRAME_END)
                return 1'b0;
            case (c)
                bbfd_pkg::CMD_OUTSIDE:   publish(bbfd_pkg::SID_OUTSIDE,   v, 1'b1);
                bbfd_pkg::CMD_FLOW:      publish(bbfd_pkg::SID_FLOW,      v, 1'b0);
                bbfd_pkg::CMD_WATER:     publish(bbfd_pkg::SID_WATER,     v, 1'b0);
                bbfd_pkg::CMD_WATER_TGT: publish(bbfd_pkg::SID_WATER_TGT, v, 1'b0);
                bbfd_pkg::CMD_ERROR:     publish(bbfd_pkg::SID_ERROR,     v, 1'b0);
                bbfd_pkg::CMD_RPM:       publish(bbfd_pkg::SID_RPM,       v, 1'b0);
                bbfd_pkg::CMD_STATUS: begin
                    // status word fans out: status, pump, heat, valve
                    publish(bbfd_pkg::SID_STATUS, v, 1'b0);
                    publish(bbfd_pkg::SID_PUMP,  {7'd0, v[2]}, 1'b0);
                    publish(bbfd_pkg::SID_HEAT,  {7'd0, v[0]}, 1'b0);
                    publish(bbfd_pkg::SID_VALVE, {7'd0, v[1]}, 1'b0);
                end
                default: ;
            endcase
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // One accepted byte: slide it into the window, decode, mark run end.
    function automatic void decode_byte(input bbfd_pkg::t_byte b);
        int n0;
        n0 = pending_updates.size();
        win[win_cnt[2:0]] = b;
        win_cnt++;
        if (win_cnt == 8) begin
            if (frame_match()) begin
                win_cnt = 0;
            end else begin
                for (int i = 0; i < 7; i++) win[i] = win[i+1];
                win_cnt = 7;
            end
        end
        if (pending_updates.size() > n0) begin
            pending_updates[pending_updates.size()-1].last = 1'b1;
        end
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $display("%0t  %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
            mismatch_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, driver, receiver, monitor, watchdog
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Sender: a new byte only when the previous one went through (or none
    // is up); random gaps per send_idle_pct.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (tx_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= tx_bytes.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off once armed so the
    // frame queue fills and the input side backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cnt != 0) begin
            m_axis_tready <= 1'b0;
            hold_cnt      <= hold_cnt - 1;
        end else if (hold_armed && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_cnt      <= HOLD_CYCLES;
            hold_done     <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: predict on accepted bytes, check accepted update words.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                decode_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_updates.size() == 0) begin
                    $display("%0t  unexpected update word: expected none, got id %0d value %0d last %0d",
                             $time, m_axis_tdata[3:0], $signed(m_axis_tdata[12:4]),
                             m_axis_tlast);
                    mismatch_count++;
                end else begin
                    got_upd = pending_updates.pop_front();
                    check_field("sensor_id", got_upd.sid, m_axis_tdata[3:0]);
                    check_field("sensor_value", $signed(got_upd.value),
                                $signed(m_axis_tdata[12:4]));
                    check_field("last_of_run", got_upd.last, m_axis_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("boiler_bus_frame_decoder verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // frames packed with byte 0 in the low bits
    function automatic logic [63:0] ctrl_frame(input bbfd_pkg::t_byte c,
                                               input bbfd_pkg::t_byte v);
        return {v, bbfd_pkg::FRAME_END, v, v, c, c, bbfd_pkg::SYNC_CTRL, bbfd_pkg::SYNC_CTRL};
    endfunction

    function automatic logic [63:0] dev_frame(input bbfd_pkg::t_byte c,
                                              input bbfd_pkg::t_byte v,
                                              input bbfd_pkg::t_byte x);
        return {bbfd_pkg::FRAME_END, x, v, c, c, c, bbfd_pkg::SYNC_DEV, bbfd_pkg::SYNC_DEV};
    endfunction

    task automatic push_frame(input logic [63:0] fr);
        for (int i = 0; i < 8; i++) tx_bytes = {tx_bytes, fr[i*8 +: 8]};
    endtask

    // noise leans on sync and end bytes so partial frames show up
    function automatic bbfd_pkg::t_byte noise_byte();
        case ($urandom_range(0, 3))
            0:       return bbfd_pkg::SYNC_CTRL;
            1:       return bbfd_pkg::SYNC_DEV;
            2:       return bbfd_pkg::FRAME_END;
            default: return bbfd_pkg::t_byte'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed frames with values from a narrow range (so repeats
    // suppress updates), plus unknown commands, corrupted frames and noise.
    task automatic queue_random_traffic(input int n_bytes);
        int              added;
        int              sel;
        int              k;
        logic [63:0]     fr;
        bbfd_pkg::t_byte cmd;
        bbfd_pkg::t_byte val;
        added = 0;
        while (added < n_bytes) begin
            sel = $urandom_range(0, 99);
            val = $urandom_range(0, 1) ? bbfd_pkg::t_byte'($urandom_range(0, 3))
                                       : bbfd_pkg::t_byte'($urandom_range(0, 255));
            if (sel < 15) begin
                k = $urandom_range(1, 5);
                repeat (k) tx_bytes = {tx_bytes, noise_byte()};
                added += k;
            end else begin
                if ($urandom_range(0, 1)) begin
                    cmd = (sel < 85) ? CTRL_CMDS[$urandom_range(0, 4)]
                                     : bbfd_pkg::t_byte'($urandom_range(0, 255));
                    fr  = ctrl_frame(cmd, val);
                end else begin
                    cmd = (sel < 85) ? DEV_CMDS[$urandom_range(0, 6)]
                                     : bbfd_pkg::t_byte'($urandom_range(0, 255));
                    fr  = dev_frame(cmd, val, bbfd_pkg::t_byte'($urandom_range(0, 255)));
                end
                if (sel >= 70 && sel < 85) begin
                    k = $urandom_range(0, 7);
                    fr[k*8 +: 8] = bbfd_pkg::t_byte'($urandom_range(0, 255));
                end
                push_frame(fr);
                added += 8;
            end
        end
    endtask

    task automatic write_enable(input logic [14:0] mask);
        @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= mask;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        mdl_enable   = mask;
    endtask

    // all bytes in, all updates out, then let silent frames drain
    task automatic wait_drained();
        while (tx_bytes.size() != 0 || s_axis_tvalid || pending_updates.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every command, value extremes, repeats, unknown and broken
        send_idle_pct = 23;
        recv_idle_pct = 77;
        write_enable(15'h7FFF);
        push_frame(ctrl_frame(bbfd_pkg::CMD_FLOW_TGT, 8'h00));  // first publish of reset value
        push_frame(ctrl_frame(bbfd_pkg::CMD_FLOW_TGT, 8'h00));  // unchanged: silent
        push_frame(ctrl_frame(bbfd_pkg::CMD_HEAT_DAY, 8'hFF));
        push_frame(ctrl_frame(bbfd_pkg::CMD_WATER_DAY, 8'h7F));
        push_frame(ctrl_frame(bbfd_pkg::CMD_MODE, 8'h01));
        push_frame(ctrl_frame(bbfd_pkg::CMD_DWT_OUT, 8'h80));   // most negative
        push_frame(dev_frame(bbfd_pkg::CMD_OUTSIDE, 8'hFF, 8'hAA));
        push_frame(dev_frame(bbfd_pkg::CMD_FLOW, 8'h00, 8'h00));
        push_frame(dev_frame(bbfd_pkg::CMD_WATER, 8'h55, 8'hFF));
        push_frame(dev_frame(bbfd_pkg::CMD_WATER_TGT, 8'hAA, 8'h06));
        push_frame(dev_frame(bbfd_pkg::CMD_ERROR, 8'h01, 8'h44));
        push_frame(dev_frame(bbfd_pkg::CMD_RPM, 8'hFE, 8'h53));
        push_frame(dev_frame(bbfd_pkg::CMD_STATUS, 8'h07, 8'h00)); // all four outputs
        push_frame(dev_frame(bbfd_pkg::CMD_STATUS, 8'h05, 8'h00)); // status and valve only
        push_frame(ctrl_frame(8'h00, 8'h12));            // unknown controller cmd
        push_frame(dev_frame(8'hFF, 8'h34, 8'h00));      // unknown device cmd
        push_frame(ctrl_frame(bbfd_pkg::CMD_MODE, 8'h02) ^ {8'h01, 56'd0});  // bad trailing value
        push_frame(dev_frame(bbfd_pkg::CMD_FLOW, 8'h09, 8'h00) ^ {8'hFF, 56'd0});
        tx_bytes = {tx_bytes, bbfd_pkg::SYNC_CTRL};
        tx_bytes = {tx_bytes, bbfd_pkg::SYNC_CTRL};
        tx_bytes = {tx_bytes, bbfd_pkg::SYNC_DEV};
        push_frame(ctrl_frame(bbfd_pkg::CMD_DWT_OUT, 8'h7F));   // resync after noise
        wait_drained();

        // everything masked off: nothing may come out, model state frozen
        write_enable(15'h0000);
        queue_random_traffic(24);
        wait_drained();

        // random mask, sender mostly idle, receiver mostly ready
        send_idle_pct = 77;
        recv_idle_pct = 23;
        write_enable(15'($urandom_range(1, 32766)));
        queue_random_traffic(104);
        wait_drained();

        // all enabled, no idling, one long output hold-off to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_enable(15'h7FFF);
        hold_armed <= 1'b1;
        queue_random_traffic(136);
        wait_drained();

        if (mismatch_count == 0) begin
            $display("boiler_bus_frame_decoder verification clean");
        end else begin
            $display("boiler_bus_frame_decoder verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/bbfd_pkg.sv
rtl/core/bbfd_front.sv
rtl/core/bbfd_queue.sv
rtl/core/bbfd_back.sv
rtl/core/boiler_bus_frame_decoder.sv
tb/tb_top.sv
